// File: design/fnds_pkg.sv
// Package for the free neighbor degree sorter: beat types, function codes,
// FSM states, sizing constants and the sort order. No dependencies.
package fnds_pkg;

   localparam int GRAPH_WIDTH        = 64;
   localparam int GROUP_BITS         = 8;
   localparam int GROUPS             = GRAPH_WIDTH / GROUP_BITS;
   localparam int COUNT_BITS         = 7;
   localparam int DEF_NODES          = 64;
   localparam int DEF_MAX_CANDIDATES = 64;

   localparam logic [1:0] FUNC_ADJ  = 2'd0;
   localparam logic [1:0] FUNC_FREE = 2'd1;
   localparam logic [1:0] FUNC_CAND = 2'd2;

   typedef logic [GRAPH_WIDTH-1:0] graph_row_type;
   typedef logic [3:0]             group_count_type;

   typedef struct packed {
      logic [1:0] func;
      logic [5:0] node_a;
      logic [5:0] node_b;
      logic       bit_value;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [5:0]  node;
      logic [5:0]  degree;
      logic [11:0] total_degree;
      logic        last_out;
   } rsp_type;

   typedef struct packed {
      logic       valid;
      logic [5:0] degree;
      logic [5:0] node;
   } entry_type;

   typedef struct packed {
      logic      insert;
      logic      pop;
      entry_type entry;
   } chain_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADJ_A,
      ST_ADJ_B,
      ST_CAND_RD,
      ST_CAND_SUM,
      ST_CAND_INS,
      ST_EMIT
   } state_type;

   // True when entry a must stand ahead of entry b in the sorted run.
   function automatic logic goes_first(entry_type a, entry_type b);
      logic result;
      if (a.degree != b.degree) begin
         result = (a.degree > b.degree);
      end else begin
         result = (a.node < b.node);
      end
      return result;
   endfunction

endpackage

// File: design/free_neighbor_degree_sorter.sv
// Free neighbor degree sorter, top level.
// Adjacency write: read and rewrite of two rows through the single RAM port
// pair. Candidate: row read, two popcount stages, chain insert. Requests
// stall outside the idle state. The sorted run follows the last candidate
// at one result per cycle while rsp_stall is low. Reset clears the adjacency
// rows at once through per-row valid bits; no clearing pass. Uses fnds_pkg.
module free_neighbor_degree_sorter #(
   parameter int NODES          = fnds_pkg::DEF_NODES,
   parameter int MAX_CANDIDATES = fnds_pkg::DEF_MAX_CANDIDATES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fnds_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fnds_pkg::rsp_type rsp_data
);
   import fnds_pkg::*;

   localparam int NODE_BITS = $clog2(NODES);
   localparam logic [COUNT_BITS-1:0] FULL       = COUNT_BITS'(MAX_CANDIDATES);
   localparam logic [6:0]            NODE_LIMIT = 7'(NODES);
   localparam logic [NODES-1:0]      ONE        = {{(NODES-1){1'b0}}, 1'b1};

   state_type               state_ff, state_in;
   req_type                 item_ff;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic [11:0]             sum_ff, sum_in;
   logic [NODES-1:0]        free_ff, free_in;
   logic [NODES-1:0]        row_valid_ff, row_valid_in;

   logic                    ram_wr_en, ram_rd_en;
   logic [NODE_BITS-1:0]    ram_wr_addr, ram_rd_addr;
   logic [NODES-1:0]        ram_wr_data, ram_rd_data;

   logic                    req_a_ok, req_b_ok, item_a_ok;
   logic [NODE_BITS-1:0]    req_idx_a, item_idx_a, item_idx_b;
   logic [NODES-1:0]        old_row_a, old_row_b, row_upd_a, row_upd_b;
   logic [NODES-1:0]        bit_a, bit_b, deg_bits;
   logic [5:0]              degree;
   logic                    accept;
   logic                    last_out;

   chain_cmd_type           cmd;
   entry_type               ent [MAX_CANDIDATES+1];
   logic                    bef [MAX_CANDIDATES];

   assign req_a_ok   = ({1'b0, req_data.node_a} < NODE_LIMIT);
   assign req_b_ok   = ({1'b0, req_data.node_b} < NODE_LIMIT);
   assign item_a_ok  = ({1'b0, item_ff.node_a} < NODE_LIMIT);
   assign req_idx_a  = req_data.node_a[NODE_BITS-1:0];
   assign item_idx_a = item_ff.node_a[NODE_BITS-1:0];
   assign item_idx_b = item_ff.node_b[NODE_BITS-1:0];

   assign bit_a     = ONE << item_idx_a;
   assign bit_b     = ONE << item_idx_b;
   assign old_row_a = ram_rd_data & {NODES{row_valid_ff[item_idx_a]}};
   assign old_row_b = ram_rd_data & {NODES{row_valid_ff[item_idx_b]}};
   assign row_upd_a = item_ff.bit_value ? (old_row_a | bit_b) : (old_row_a & ~bit_b);
   assign row_upd_b = item_ff.bit_value ? (old_row_b | bit_a) : (old_row_b & ~bit_a);
   assign deg_bits  = old_row_a & free_ff & ~bit_a & {NODES{item_a_ok}};

   assign accept   = req_valid && !req_stall;
   assign last_out = !ent[1].valid;

   fnds_ram #(
      .WIDTH (NODES),
      .DEPTH (NODES)
   ) u_adj_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   fnds_degree u_degree (
      .clock  (clock),
      .bits   (graph_row_type'(deg_bits)),
      .degree (degree)
   );

   assign ent[MAX_CANDIDATES] = '0;

   for (genvar i = 0; i < MAX_CANDIDATES; i++) begin : g_chain
      if (i == 0) begin : g_head
         fnds_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .cmd         (cmd),
            .prev_entry  (cmd.entry),
            .prev_before (1'b0),
            .next_entry  (ent[i+1]),
            .entry_out   (ent[i]),
            .before_out  (bef[i])
         );
      end else begin : g_body
         fnds_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .cmd         (cmd),
            .prev_entry  (ent[i-1]),
            .prev_before (bef[i-1]),
            .next_entry  (ent[i+1]),
            .entry_out   (ent[i]),
            .before_out  (bef[i])
         );
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      free_in      = free_ff;
      row_valid_in = row_valid_ff;
      req_stall    = (state_ff != ST_IDLE);
      rsp_valid    = 1'b0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = req_idx_a;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = item_idx_a;
      ram_wr_data  = row_upd_a;
      cmd          = '0;
      cmd.entry    = '{valid: 1'b1, degree: degree, node: item_ff.node_a};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_data.func)
                  FUNC_ADJ: begin
                     if (req_a_ok && req_b_ok) begin
                        ram_rd_en = 1'b1;
                        state_in  = ST_ADJ_A;
                     end
                  end
                  FUNC_FREE: begin
                     if (req_a_ok) begin
                        free_in[req_idx_a] = req_data.bit_value;
                     end
                  end
                  FUNC_CAND: begin
                     if (count_ff != FULL) begin
                        ram_rd_en = 1'b1;
                        state_in  = ST_CAND_RD;
                     end else if (req_data.last) begin
                        state_in = ST_EMIT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ADJ_A: begin
            ram_wr_en                = 1'b1;
            row_valid_in[item_idx_a] = 1'b1;
            ram_rd_en                = 1'b1;
            ram_rd_addr              = item_idx_b;
            state_in                 = ST_ADJ_B;
         end
         ST_ADJ_B: begin
            // A self loop is complete after the first row write.
            ram_wr_en                = (item_idx_b != item_idx_a);
            ram_wr_addr              = item_idx_b;
            ram_wr_data              = row_upd_b;
            row_valid_in[item_idx_b] = 1'b1;
            state_in                 = ST_IDLE;
         end
         ST_CAND_RD: begin
            state_in = ST_CAND_SUM;
         end
         ST_CAND_SUM: begin
            state_in = ST_CAND_INS;
         end
         ST_CAND_INS: begin
            cmd.insert = 1'b1;
            count_in   = count_ff + COUNT_BITS'(1);
            sum_in     = sum_ff + 12'(degree);
            state_in   = item_ff.last ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               cmd.pop = 1'b1;
               if (last_out) begin
                  count_in = '0;
                  sum_in   = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         sum_ff       <= '0;
         free_ff      <= '0;
         row_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         free_ff      <= free_in;
         row_valid_ff <= row_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
      end
   end

   assign rsp_data.node         = ent[0].node;
   assign rsp_data.degree       = ent[0].degree;
   assign rsp_data.total_degree = sum_ff;
   assign rsp_data.last_out     = last_out;
endmodule

// File: design/fnds_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module fnds_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: design/fnds_degree.sv
// Two-stage population count of a masked adjacency row.
// Depends on fnds_pkg.
module fnds_degree (
   input  logic                  clock,
   input  fnds_pkg::graph_row_type bits,
   output logic [5:0]            degree
);
   import fnds_pkg::*;

   group_count_type grp_ff [GROUPS];
   group_count_type grp_in [GROUPS];
   logic [5:0]      degree_ff;
   logic [5:0]      degree_in;

   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_in[g] = '0;
         for (int j = 0; j < GROUP_BITS; j++) begin
            grp_in[g] = grp_in[g] + group_count_type'(bits[g*GROUP_BITS+j]);
         end
      end
   end

   always_comb begin
      logic [6:0] sum;
      sum = '0;
      for (int g = 0; g < GROUPS; g++) begin
         sum = sum + 7'(grp_ff[g]);
      end
      degree_in = sum[5:0];
   end

   always_ff @(posedge clock) begin
      grp_ff    <= grp_in;
      degree_ff <= degree_in;
   end

   assign degree = degree_ff;
endmodule

// File: design/fnds_cell.sv
// One cell of the sorted candidate chain: holds one entry, takes a new
// entry or its neighbor's on insert, and shifts toward the head on pop.
// Depends on fnds_pkg.
module fnds_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  fnds_pkg::chain_cmd_type cmd,
   input  fnds_pkg::entry_type     prev_entry,
   input  logic                    prev_before,
   input  fnds_pkg::entry_type     next_entry,
   output fnds_pkg::entry_type     entry_out,
   output logic                    before_out
);
   import fnds_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   assign before_out = !entry_ff.valid || goes_first(cmd.entry, entry_ff);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.pop) begin
         entry_in = next_entry;
      end else if (cmd.insert && before_out) begin
         entry_in = prev_before ? prev_entry : cmd.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry_out = entry_ff;
endmodule
